[rtl/etep_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the export table entry parser.
// No dependencies; every other file in rtl/ but etep_ifs refers to this package.
package etep_pkg;

  // Field of an export entry that the front end is currently decoding.
  typedef enum logic [2:0] {
    PH_CLASS  = 3'd0,
    PH_PARENT = 3'd1,
    PH_GROUP  = 3'd2,
    PH_NAME   = 3'd3,
    PH_FLAGS  = 3'd4,
    PH_SIZE   = 3'd5,
    PH_OFFSET = 3'd6
  } phase_t;

  // One finished field, passed from the front end to the back end.
  typedef struct packed {
    phase_t      phase;
    logic [32:0] value;
    logic        emit;
    logic        last;
  } field_evt_t;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] CI_SIGN_BIT  = 8'h80;
  localparam logic [7:0] CI_MORE_BIT  = 8'h40;
  localparam logic [7:0] CI_HEAD_MASK = 8'h3f;
  localparam logic [7:0] CI_MID_MASK  = 8'h7f;
  localparam logic [7:0] CI_TAIL_MASK = 8'h1f;
  localparam logic [4:0] CI_TAIL_SHIFT = 5'd27;

endpackage

[rtl/etep_ifs.sv]
`timescale 1ns / 1ps
// Channel interfaces of the export table entry parser: byte input,
// configuration write and entry result. Depends on nothing.

interface etep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       table_start;
  modport source (output valid, output data_byte, output table_start, input ready);
  modport sink   (input valid, input data_byte, input table_start, output ready);
endinterface

interface etep_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_count;
  modport source (output valid, output entry_count, input ready);
  modport sink   (input valid, input entry_count, output ready);
endinterface

interface etep_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] class_ref;
  logic signed [32:0] parent_ref;
  logic        [31:0] group_word;
  logic signed [32:0] name_ref;
  logic        [31:0] object_flags;
  logic signed [32:0] serial_size;
  logic signed [32:0] serial_offset;
  logic               table_done;
  modport source (output valid, output class_ref, output parent_ref, output group_word,
                  output name_ref, output object_flags, output serial_size,
                  output serial_offset, output table_done, input ready);
  modport sink   (input valid, input class_ref, input parent_ref, input group_word,
                  input name_ref, input object_flags, input serial_size,
                  input serial_offset, input table_done, output ready);
endinterface

[rtl/export_table_entry_parser.sv]
`timescale 1ns / 1ps
// Export table entry parser: takes one table byte per transaction and returns one
// transaction per decoded entry (class, parent, group, name, flags, size, offset, last flag).
// It sustains one byte per clock while the event queue has room; the front end finishes
// a field in the cycle of its final byte; entries reach the output register via the queue.
// The input stalls only when the event queue between front and back end is full, which
// happens only while results wait at the output. Write entry_count while the block is idle.
// Depends on etep_pkg, etep_ifs, etep_front, etep_fifo and etep_back.
module export_table_entry_parser #(
  parameter int unsigned FIFO_DEPTH = etep_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  etep_in_if.sink     in_chan,
  etep_cfg_if.sink    cfg_chan,
  etep_out_if.source  out_chan
);

  logic [15:0]          entry_count_r;
  logic                 evt_push, evt_full, evt_pop, evt_valid;
  etep_pkg::field_evt_t evt_in, evt_out;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= 16'd0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      entry_count_r <= cfg_chan.entry_count;
    end
  end

  etep_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .entry_count (entry_count_r),
    .evt_full    (evt_full),
    .evt_push    (evt_push),
    .evt         (evt_in)
  );

  etep_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (evt_in),
    .full      (evt_full),
    .pop       (evt_pop),
    .not_empty (evt_valid),
    .pop_data  (evt_out)
  );

  etep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt       (evt_out),
    .evt_pop   (evt_pop),
    .out_chan  (out_chan)
  );

endmodule

[rtl/etep_front.sv]
`timescale 1ns / 1ps
// Front end: accepts table bytes, decodes compact indices and 32-bit words,
// counts entries and pushes one event per finished field. Uses etep_pkg, etep_ifs.
module etep_front (
  input  logic                   clk,
  input  logic                   rst_n,
  etep_in_if.sink                in_chan,
  input  logic [15:0]            entry_count,
  input  logic                   evt_full,
  output logic                   evt_push,
  output etep_pkg::field_evt_t   evt
);

  etep_pkg::phase_t phase_r, phase_nxt, ph;
  logic [2:0]  pos_r, pos_nxt, pos;
  logic        sign_r, sign_nxt, sgn;
  logic [31:0] acc_r, acc_nxt, acc;
  logic [15:0] ed_r, ed_nxt, ed;
  logic [2:0]  pos_inc;
  logic        ci_done;
  logic [32:0] ci_val;
  logic        accept;
  logic [7:0]  b;

  assign in_chan.ready = !evt_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;

  always_comb begin
    // A table start clears the parser before its byte is used.
    ph  = in_chan.table_start ? etep_pkg::PH_CLASS : phase_r;
    pos = in_chan.table_start ? 3'd0 : pos_r;
    sgn = in_chan.table_start ? 1'b0 : sign_r;
    acc = in_chan.table_start ? 32'd0 : acc_r;
    ed  = in_chan.table_start ? 16'd0 : ed_r;

    phase_nxt = ph;
    pos_nxt   = pos;
    sign_nxt  = sgn;
    acc_nxt   = acc;
    ed_nxt    = ed;
    pos_inc   = pos + 3'd1;
    ci_done   = 1'b0;
    ci_val    = '0;
    evt_push  = 1'b0;
    evt.phase = ph;
    evt.value = '0;
    evt.emit  = 1'b0;
    evt.last  = ({1'b0, ed} + 17'd1) == {1'b0, entry_count};

    if (ed >= entry_count) begin
      // Count reached: the byte is dropped.
    end else if (ph == etep_pkg::PH_GROUP || ph == etep_pkg::PH_FLAGS) begin
      acc_nxt = acc | ({24'd0, b} << {pos[1:0], 3'b000});
      pos_nxt = pos_inc;
      if (pos_inc >= 3'd4) begin
        evt_push  = 1'b1;
        evt.value = {1'b0, acc_nxt};
        phase_nxt = (ph == etep_pkg::PH_GROUP) ? etep_pkg::PH_NAME : etep_pkg::PH_SIZE;
        pos_nxt   = 3'd0;
        acc_nxt   = 32'd0;
      end
    end else begin
      priority if (pos == 3'd0) begin
        sign_nxt = (b & etep_pkg::CI_SIGN_BIT) != 8'd0;
        acc_nxt  = {24'd0, b & etep_pkg::CI_HEAD_MASK};
        ci_done  = (b & etep_pkg::CI_MORE_BIT) == 8'd0;
      end else if (pos == 3'd1) begin
        acc_nxt = acc | ({25'd0, b[6:0] & etep_pkg::CI_MID_MASK[6:0]} << 6);
        ci_done = !b[7];
      end else if (pos == 3'd2) begin
        acc_nxt = acc | ({25'd0, b[6:0] & etep_pkg::CI_MID_MASK[6:0]} << 13);
        ci_done = !b[7];
      end else if (pos == 3'd3) begin
        acc_nxt = acc | ({25'd0, b[6:0] & etep_pkg::CI_MID_MASK[6:0]} << 20);
        ci_done = !b[7];
      end else begin
        acc_nxt = acc | ({27'd0, b[4:0] & etep_pkg::CI_TAIL_MASK[4:0]}
                         << etep_pkg::CI_TAIL_SHIFT);
        ci_done = 1'b1;
      end
      pos_nxt = pos_inc;
      ci_val  = sign_nxt ? (33'd0 - {1'b0, acc_nxt}) : {1'b0, acc_nxt};

      if (ci_done) begin
        evt_push  = 1'b1;
        evt.value = ci_val;
        pos_nxt   = 3'd0;
        unique case (ph)
          etep_pkg::PH_PARENT: phase_nxt = etep_pkg::PH_GROUP;
          etep_pkg::PH_NAME:   phase_nxt = etep_pkg::PH_FLAGS;
          etep_pkg::PH_SIZE: begin
            // A positive size is followed by an offset; otherwise the entry ends here.
            if (!sign_nxt && acc_nxt != 32'd0) begin
              phase_nxt = etep_pkg::PH_OFFSET;
            end else begin
              phase_nxt = etep_pkg::PH_CLASS;
              evt.emit  = 1'b1;
              ed_nxt    = ed + 16'd1;
            end
          end
          etep_pkg::PH_OFFSET: begin
            phase_nxt = etep_pkg::PH_CLASS;
            evt.emit  = 1'b1;
            ed_nxt    = ed + 16'd1;
          end
          default: begin
            // The class field, and the unused phase code that behaves as class.
            evt.phase = etep_pkg::PH_CLASS;
            phase_nxt = etep_pkg::PH_PARENT;
          end
        endcase
        acc_nxt  = 32'd0;
        sign_nxt = 1'b0;
      end
    end

    if (!accept) begin
      evt_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= etep_pkg::PH_CLASS;
      pos_r   <= 3'd0;
      sign_r  <= 1'b0;
      acc_r   <= 32'd0;
      ed_r    <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sign_r  <= sign_nxt;
      acc_r   <= acc_nxt;
      ed_r    <= ed_nxt;
    end
  end

endmodule

[rtl/etep_fifo.sv]
`timescale 1ns / 1ps
// Short queue of field events between the front end and the back end.
// Uses etep_pkg for the event type.
module etep_fifo #(
  parameter int unsigned DEPTH = etep_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  etep_pkg::field_evt_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output etep_pkg::field_evt_t pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  etep_pkg::field_evt_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/etep_back.sv]
`timescale 1ns / 1ps
// Back end: collects field events into the entry holds and loads the result
// register when an entry ends. Uses etep_pkg and etep_out_if.
module etep_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 evt_valid,
  input  etep_pkg::field_evt_t evt,
  output logic                 evt_pop,
  etep_out_if.source           out_chan
);

  logic [32:0] class_hold_r, parent_hold_r, name_hold_r, size_hold_r;
  logic [31:0] group_hold_r, flags_hold_r;
  logic        out_valid_r;
  logic [32:0] o_class_r, o_parent_r, o_name_r, o_size_r, o_offset_r;
  logic [31:0] o_group_r, o_flags_r;
  logic        o_done_r;

  assign evt_pop = evt_valid && (!out_valid_r || out_chan.ready);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.class_ref     = o_class_r;
  assign out_chan.parent_ref    = o_parent_r;
  assign out_chan.group_word    = o_group_r;
  assign out_chan.name_ref      = o_name_r;
  assign out_chan.object_flags  = o_flags_r;
  assign out_chan.serial_size   = o_size_r;
  assign out_chan.serial_offset = o_offset_r;
  assign out_chan.table_done    = o_done_r;

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      unique case (evt.phase)
        etep_pkg::PH_CLASS:  class_hold_r  <= evt.value;
        etep_pkg::PH_PARENT: parent_hold_r <= evt.value;
        etep_pkg::PH_GROUP:  group_hold_r  <= evt.value[31:0];
        etep_pkg::PH_NAME:   name_hold_r   <= evt.value;
        etep_pkg::PH_FLAGS:  flags_hold_r  <= evt.value[31:0];
        etep_pkg::PH_SIZE:   size_hold_r   <= evt.value;
        default: ;
      endcase
      if (evt.emit) begin
        // An entry ends either on a non-positive size or on its offset.
        o_class_r  <= class_hold_r;
        o_parent_r <= parent_hold_r;
        o_group_r  <= group_hold_r;
        o_name_r   <= name_hold_r;
        o_flags_r  <= flags_hold_r;
        o_size_r   <= (evt.phase == etep_pkg::PH_SIZE) ? evt.value : size_hold_r;
        o_offset_r <= (evt.phase == etep_pkg::PH_OFFSET) ? evt.value : 33'd0;
        o_done_r   <= evt.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (evt_pop && evt.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for export_table_entry_parser: random export tables, byte by byte.
// Needs etep_pkg, the etep_ifs channel interfaces and the parser RTL; it reads no files.
module tb;
  import etep_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int TARGET_BYTES  = 1350;
  localparam int QUIET_BYTES   = 1150;

  typedef struct packed {
    logic [32:0] class_ref;
    logic [32:0] parent_ref;
    logic [31:0] group_word;
    logic [32:0] name_ref;
    logic [31:0] object_flags;
    logic [32:0] serial_size;
    logic [32:0] serial_offset;
    logic        table_done;
  } entry_t;

  // Decodes the byte stream alongside the block and holds the entries it should return.
  class entry_decode_board;
    logic [15:0] entry_count;
    phase_t      phase;
    logic [2:0]  pos;
    logic        neg;
    logic [31:0] acc;
    entry_t      held;
    logic [15:0] entries_done;
    entry_t      pending_entries[$];
    int          mismatches;
    int          entries_checked;
    int          last_marks;

    function new();
      entry_count     = '0;
      entries_done    = '0;
      mismatches      = 0;
      entries_checked = 0;
      last_marks      = 0;
      clear_fields();
    endfunction

    function void clear_fields();
      phase = PH_CLASS;
      pos   = '0;
      neg   = 1'b0;
      acc   = '0;
      held  = '0;
    endfunction

    function void set_count(logic [15:0] c);
      entry_count = c;
    endfunction

    function void finish_entry(logic [32:0] offset);
      entry_t e;
      e = held;
      e.serial_offset = offset;
      e.table_done = ({1'b0, entries_done} + 17'd1 == {1'b0, entry_count});
      pending_entries.push_back(e);
      entries_done = entries_done + 16'd1;
      phase = PH_CLASS;
      pos   = '0;
      acc   = '0;
      neg   = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic start);
      logic        last_byte;
      logic [32:0] value;
      if (start) begin
        clear_fields();
        entries_done = '0;
      end
      if (entries_done >= entry_count) return;

      // Group and flags are plain little-endian words.
      if (phase == PH_GROUP || phase == PH_FLAGS) begin
        acc = acc | (32'(b) << (8 * int'(pos[1:0])));
        pos = pos + 3'd1;
        if (pos >= 3'd4) begin
          if (phase == PH_GROUP) held.group_word = acc;
          else held.object_flags = acc;
          phase = phase_t'(phase + 3'd1);
          pos   = '0;
          acc   = '0;
        end
        return;
      end

      if (pos == 3'd0) begin
        neg       = b[7];
        acc       = {26'd0, b[5:0]};
        last_byte = !b[6];
      end else if (pos < 3'd4) begin
        acc       = acc | (32'(b[6:0]) << (7 * int'(pos) - 1));
        last_byte = !b[7];
      end else begin
        acc       = acc | (32'(b[4:0]) << 27);
        last_byte = 1'b1;
      end
      pos = pos + 3'd1;
      if (!last_byte) return;

      value = neg ? (33'd0 - {1'b0, acc}) : {1'b0, acc};
      pos = '0;
      case (phase)
        PH_PARENT: begin
          held.parent_ref = value;
          phase = PH_GROUP;
        end
        PH_NAME: begin
          held.name_ref = value;
          phase = PH_FLAGS;
        end
        PH_SIZE: begin
          held.serial_size = value;
          // Only a strictly positive size is followed by an offset.
          if (!neg && acc != 0) begin
            phase = PH_OFFSET;
          end else begin
            finish_entry('0);
            return;
          end
        end
        PH_OFFSET: begin
          finish_entry(value);
          return;
        end
        default: begin
          held.class_ref = value;
          phase = PH_PARENT;
        end
      endcase
      acc = '0;
      neg = 1'b0;
    endfunction

    function int pending();
      return pending_entries.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task compare_field(string field, logic [32:0] got, logic [32:0] want);
      if (got !== want)
        report($sformatf("entry %0d %s is %h, expected %h", entries_checked, field, got, want));
    endtask

    task check_entry(entry_t got);
      entry_t want;
      entries_checked++;
      if (pending_entries.size() == 0) begin
        report($sformatf("entry %0d arrived with none expected", entries_checked));
        return;
      end
      want = pending_entries.pop_front();
      if (want.table_done) last_marks++;
      compare_field("class_ref", got.class_ref, want.class_ref);
      compare_field("parent_ref", got.parent_ref, want.parent_ref);
      compare_field("group_word", {1'b0, got.group_word}, {1'b0, want.group_word});
      compare_field("name_ref", got.name_ref, want.name_ref);
      compare_field("object_flags", {1'b0, got.object_flags}, {1'b0, want.object_flags});
      compare_field("serial_size", got.serial_size, want.serial_size);
      compare_field("serial_offset", got.serial_offset, want.serial_offset);
      compare_field("table_done", {32'd0, got.table_done}, {32'd0, want.table_done});
    endtask
  endclass

  logic clk;
  logic rst_n;

  etep_in_if  in_if ();
  etep_cfg_if cfg_if ();
  etep_out_if out_if ();

  export_table_entry_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .cfg_chan (cfg_if),
    .out_chan (out_if)
  );

  entry_decode_board board;
  entry_t            seen;
  bit                quiet;
  int                bytes_sent;
  int                tables_run;
  int                count_writes;
  logic [7:0]        table_bytes[$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results are checked before the byte of the same edge is decoded.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen.class_ref     = out_if.class_ref;
        seen.parent_ref    = out_if.parent_ref;
        seen.group_word    = out_if.group_word;
        seen.name_ref      = out_if.name_ref;
        seen.object_flags  = out_if.object_flags;
        seen.serial_size   = out_if.serial_size;
        seen.serial_offset = out_if.serial_offset;
        seen.table_done    = out_if.table_done;
        board.check_entry(seen);
      end
      if (cfg_if.valid && cfg_if.ready) board.set_count(cfg_if.entry_count);
      if (in_if.valid && in_if.ready) board.take_byte(in_if.data_byte, in_if.table_start);
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_magnitude();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'($urandom_range(0, 63));
      2:       return 32'hffff_ffff;
      3:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_word(logic [31:0] w);
    table_bytes.push_back(w[7:0]);
    table_bytes.push_back(w[15:8]);
    table_bytes.push_back(w[23:16]);
    table_bytes.push_back(w[31:24]);
  endfunction

  // Compact index, usually in its shortest form, sometimes padded with zero groups.
  function automatic void push_index(logic sign, logic [31:0] mag);
    int         len;
    logic [7:0] b;
    if (mag < 32'd64) len = 1;
    else if (mag < 32'd8192) len = 2;
    else if (mag < 32'h0010_0000) len = 3;
    else if (mag < 32'h0800_0000) len = 4;
    else len = 5;
    if (len < 5 && $urandom_range(0, 7) == 0) len = $urandom_range(len + 1, 5);
    b = {sign, 1'(len > 1), mag[5:0]};
    table_bytes.push_back(b);
    for (int k = 1; k < len; k++) begin
      if (k < 4) b = {1'(k < len - 1), 7'(mag >> (7 * k - 1))};
      else b = {3'($urandom), mag[31:27]};
      table_bytes.push_back(b);
    end
  endfunction

  function automatic void push_entry();
    logic        sign;
    logic [31:0] mag;
    push_index($urandom_range(0, 3) == 0, pick_magnitude());
    push_index($urandom_range(0, 3) == 0, pick_magnitude());
    push_word(pick_word());
    push_index($urandom_range(0, 3) == 0, pick_magnitude());
    push_word(pick_word());
    sign = ($urandom_range(0, 2) == 0);
    mag  = pick_magnitude();
    push_index(sign, mag);
    if (!sign && mag != 0) push_index($urandom_range(0, 3) == 0, pick_magnitude());
  endfunction

  task automatic send_byte(logic [7:0] b, logic start);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.table_start <= start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_results();
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Idle point for a register write: no results owed and the pipeline drained.
  task automatic settle();
    in_if.valid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [15:0] c);
    cfg_if.valid       <= 1'b1;
    cfg_if.entry_count <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    count_writes++;
  endtask

  task automatic send_range(int first, int stop, bit open_table, int pause_at);
    logic start;
    for (int k = first; k < stop; k++) begin
      if (k == pause_at) begin
        in_if.valid <= 1'b0;
        wait_results();
      end
      // A rare restart in the middle of a table breaks the entry in progress.
      start = (open_table && k == first) || ($urandom_range(0, 149) == 0);
      send_byte(table_bytes[k], start);
    end
  endtask

  task automatic run_table(logic [15:0] count, int entries, bit lower_midway, int pause_at);
    int cut;
    table_bytes.delete();
    for (int k = 0; k < entries; k++) push_entry();
    if (pause_at < 0 && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, table_bytes.size() - 1);
      while (table_bytes.size() > cut) void'(table_bytes.pop_back());
    end
    repeat ($urandom_range(0, 3)) table_bytes.push_back(8'($urandom));
    settle();
    write_count(count);
    if (lower_midway && table_bytes.size() > 1) begin
      cut = $urandom_range(1, table_bytes.size() - 1);
      send_range(0, cut, 1'b1, pause_at);
      settle();
      write_count(16'($urandom_range(0, count)));
      send_range(cut, table_bytes.size(), 1'b0, pause_at);
    end else begin
      send_range(0, table_bytes.size(), 1'b1, pause_at);
    end
    tables_run++;
  endtask

  initial begin
    logic [15:0] count;
    int          entries;
    bit          lower_midway;
    int          pause_at;
    int          waited;

    board        = new();
    quiet        = 1'b0;
    bytes_sent   = 0;
    tables_run   = 0;
    count_writes = 0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= '0;
    in_if.table_start  <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.entry_count <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // One entry at the extremes: negative zero class, largest positive parent, all-ones
    // group, most negative name, zero flags, size one with offset minus one padded to two
    // bytes, then a byte past the count that must be ignored.
    table_bytes = '{8'h80,
                    8'h7f, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'h00, 8'h00, 8'h00, 8'h00,
                    8'h01,
                    8'hc1, 8'h00,
                    8'h5a};
    settle();
    write_count(16'd1);
    send_range(0, table_bytes.size(), 1'b1, -1);
    tables_run++;

    while (bytes_sent < TARGET_BYTES) begin
      quiet        = (bytes_sent > QUIET_BYTES) || ($urandom_range(0, 4) == 0);
      lower_midway = ($urandom_range(0, 6) == 0);
      pause_at     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : -1;
      if (tables_run == 1) begin
        count   = 16'hffff;
        entries = $urandom_range(1, 3);
      end else if (tables_run == 2) begin
        count   = 16'd0;
        entries = 1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            count   = 16'd0;
            entries = 1;
          end
          1: begin
            count   = 16'hffff;
            entries = 2;
          end
          default: begin
            count   = 16'($urandom_range(1, 6));
            entries = count;
            case ($urandom_range(0, 3))
              0:       entries = count + 1;
              1:       if (count > 1) entries = count - 1;
              default: ;
            endcase
          end
        endcase
      end
      // Make sure the sender waits for the block to drain at least once mid-table.
      if (tables_run == 3) pause_at = 1;
      run_table(count, entries, lower_midway, pause_at);
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (board.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d expected entries never arrived", board.pending()));

    $display("Run covered %0d table bytes in %0d tables with %0d entry count writes.",
             bytes_sent, tables_run, count_writes);
    $display("%0d decoded entries checked, %0d of them closing a table.",
             board.entries_checked, board.last_marks);
    if (board.mismatches == 0) begin
      $display("export_table_entry_parser regression: pass");
    end else begin
      $display("export_table_entry_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("export_table_entry_parser regression: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/etep_pkg.sv
rtl/etep_ifs.sv
rtl/etep_front.sv
rtl/etep_fifo.sv
rtl/etep_back.sv
rtl/export_table_entry_parser.sv
tb/sv/tb.sv
